/* rtl/core/rgba_box_downsample_chain_core_defines.svh */
// Assertion macros for the RGBA box downsample chain core.
`ifndef RGBA_BOX_DOWNSAMPLE_CHAIN_CORE_DEFINES_SVH
`define RGBA_BOX_DOWNSAMPLE_CHAIN_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RBDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define RBDC_ASSERT_NEXT(label, cond, next, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (next)) else $error(msg);

`endif

/* rtl/core/rbdc_pkg.sv */
// Package with shared constants, types and helpers of the downsample chain.
`default_nettype none
package rbdc_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_PASSES   = 8;
    localparam int CHANNEL_MASK = 'hff;
    localparam int BOX_TAPS     = 4;

    localparam int PIXEL_W     = 32;
    localparam int CFG_W       = 13;
    localparam int PASS_W      = 4;
    localparam int FINAL_W     = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] QUARTER_LANE = 8'(CHANNEL_MASK / BOX_TAPS);

    localparam logic [CFG_W-1:0]  SIZE_RESET = CFG_W'(4096);
    localparam logic [PASS_W-1:0] PASS_RESET = PASS_W'(1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_PASS_COUNT    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [PIXEL_W-1:0] pixel;
    } t_cell_word;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_fifo_status;

    // Divide every channel by four.
    function automatic logic [PIXEL_W-1:0] quarter(input logic [PIXEL_W-1:0] px);
        return (px >> 2) & {4{QUARTER_LANE}};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/rbdc_in_if.sv */
// Input word channel of the downsample chain.
`default_nettype none
interface rbdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rbdc_pkg::PIXEL_W-1:0] in_pixel;

    modport source (output valid, output in_pixel, input ready);
    modport sink   (input valid, input in_pixel, output ready);
endinterface
`default_nettype wire

/* rtl/core/rbdc_out_if.sv */
// Output word channel of the downsample chain.
`default_nettype none
interface rbdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rbdc_pkg::PIXEL_W-1:0] out_pixel;
    logic                        out_last;
    logic [rbdc_pkg::FINAL_W-1:0] final_width;
    logic [rbdc_pkg::FINAL_W-1:0] final_height;

    modport source (output valid, output out_pixel, output out_last,
                    output final_width, output final_height, input ready);
    modport sink   (input valid, input out_pixel, input out_last,
                    input final_width, input final_height, output ready);
endinterface
`default_nettype wire

/* rtl/core/rbdc_cell.sv */
// One halving stage: column and row counters, pair sum and line store.
`default_nettype none
module rbdc_cell #(
    parameter int MAX_WIDTH = rbdc_pkg::MAX_WIDTH,
    parameter int STAGE     = 0,
    localparam int SZ_W     = $clog2(MAX_WIDTH + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire  [SZ_W-1:0]          i_width,
    input  wire  [SZ_W-1:0]          i_height,
    input  rbdc_pkg::t_cell_word     i_word,
    output rbdc_pkg::t_cell_word     o_word
);

    localparam int CNT_W     = $clog2(MAX_WIDTH);
    localparam int XW        = CNT_W + 1;
    localparam int RAW_DEPTH = MAX_WIDTH >> (STAGE + 1);
    localparam int DEPTH     = (RAW_DEPTH < 1) ? 1 : RAW_DEPTH;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [rbdc_pkg::PIXEL_W-1:0] r_line [DEPTH];

    logic [CNT_W-1:0]             r_col, n_col;
    logic [CNT_W-1:0]             r_row, n_row;
    logic [rbdc_pkg::PIXEL_W-1:0] r_pend, n_pend;
    logic [rbdc_pkg::PIXEL_W-1:0] r_sum;
    logic [rbdc_pkg::PIXEL_W-1:0] r_rd;
    logic                         r_last;
    logic                         r_valid;

    logic                         w_take;
    logic [XW-1:0]                w_wide_w, w_wide_h;
    logic [XW-1:0]                w_col_inc, w_row_inc;
    logic                         w_col_wrap, w_row_wrap;
    logic                         w_active;
    logic [CNT_W-1:0]             w_idx;
    logic [AW-1:0]                w_addr;
    logic [rbdc_pkg::PIXEL_W-1:0] w_quarter, w_sum;
    logic                         w_last;
    logic                         w_wr, w_rd;

    assign w_take     = i_en && i_word.valid;
    assign w_wide_w   = XW'(i_width);
    assign w_wide_h   = XW'(i_height);
    assign w_col_inc  = XW'(r_col) + XW'(1);
    assign w_row_inc  = XW'(r_row) + XW'(1);
    assign w_col_wrap = w_col_inc >= w_wide_w;
    assign w_row_wrap = w_row_inc >= w_wide_h;
    assign w_active   = (XW'(r_col) < (w_wide_w & ~XW'(1)))
                     && (XW'(r_row) < (w_wide_h & ~XW'(1)));
    assign w_idx      = r_col >> 1;
    assign w_addr     = AW'(w_idx);
    assign w_quarter  = rbdc_pkg::quarter(i_word.pixel);
    assign w_sum      = r_pend + w_quarter;
    assign w_last     = ((XW'(w_idx) + XW'(1)) == (w_wide_w >> 1))
                     && ((XW'(r_row >> 1) + XW'(1)) == (w_wide_h >> 1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        w_wr   = 1'b0;
        w_rd   = 1'b0;
        if (w_take) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : w_row_inc[CNT_W-1:0];
            end else begin
                n_col = w_col_inc[CNT_W-1:0];
            end
            if (w_active) begin
                if (!r_col[0]) begin
                    n_pend = w_quarter;
                end else if (!r_row[0]) begin
                    w_wr = 1'b1;
                end else begin
                    w_rd = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            if (i_en) begin
                r_valid <= w_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_sum  <= w_sum;
            r_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_line[w_addr] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd <= r_line[w_addr];
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.last  = r_last;
    assign o_word.pixel = r_sum + r_rd;

endmodule
`default_nettype wire

/* rtl/core/rbdc_out_fifo.sv */
// Two-entry output queue that parts the chain from the receiver.
`default_nettype none
module rbdc_out_fifo (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire  [rbdc_pkg::PIXEL_W-1:0]  i_pixel,
    input  wire                           i_last,
    input  wire                           i_ready,
    output logic                          o_valid,
    output logic [rbdc_pkg::PIXEL_W-1:0]  o_pixel,
    output logic                          o_last,
    output rbdc_pkg::t_fifo_status        o_status
);

    logic [rbdc_pkg::PIXEL_W:0] r_mem [2];
    logic                       r_wptr;
    logic                       r_rptr;
    logic [1:0]                 r_count, n_count;
    logic                       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = r_count != 2'd0;
    assign o_pixel = r_mem[r_rptr][rbdc_pkg::PIXEL_W-1:0];
    assign o_last  = r_mem[r_rptr][rbdc_pkg::PIXEL_W];

    always_comb begin
        unique case ({i_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= {i_last, i_pixel};
        end
    end

    assign o_status.full  = r_count == 2'd2;
    assign o_status.empty = r_count == 2'd0;
    assign o_status.count = r_count;

endmodule
`default_nettype wire

/* rtl/core/rgba_box_downsample_chain_core.sv */
// Top level of the RGBA 2x2 box-filter downsample chain.
// Feed source pixels in raster order on i_in, one word per cycle; red is in
// bits 7:0, green 15:8, blue 23:16, alpha 31:24. Each halving stage is one
// cell of the chain, and pass_count cells are active. Only words of the final
// level leave on o_out, with the final size on every word and out_last on the last one.
// Set source_width, source_height and pass_count through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle.
// Throughput: one source word per cycle while the output queue is not full,
// set by the single-port line store of each cell (one read or one write a cycle).
// Path: once the source word that completes a 2x2 block is accepted, its result
// passes one register per cell, then the output queue, before it appears on
// o_out.
// Reset clears counters, pair sums and the output queue and restores the
// register defaults of 4096 by 4096 and one pass; line stores need no clear.
// When the receiver stalls, two results queue up; once the queue is full,
// i_in.ready drops and the whole chain holds.
`default_nettype none
module rgba_box_downsample_chain_core #(
    parameter int MAX_WIDTH  = rbdc_pkg::MAX_WIDTH,
    parameter int MAX_PASSES = rbdc_pkg::MAX_PASSES
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    rbdc_in_if.sink                           i_in,
    rbdc_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire  [rbdc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire  [rbdc_pkg::CFG_W-1:0]        i_cfg_data
);

    `include "rgba_box_downsample_chain_core_defines.svh"

    localparam int SZ_W = $clog2(MAX_WIDTH + 1);
    localparam int NP_W = $clog2(MAX_PASSES + 1);

    logic [rbdc_pkg::CFG_W-1:0]  r_src_w;
    logic [rbdc_pkg::CFG_W-1:0]  r_src_h;
    logic [rbdc_pkg::PASS_W-1:0] r_pass;

    logic [SZ_W-1:0]        w_sw, w_sh;
    logic [NP_W-1:0]        w_np;
    logic                   w_en;
    logic                   w_push;
    rbdc_pkg::t_cell_word   w_cell_in [MAX_PASSES];
    rbdc_pkg::t_cell_word   w_link    [MAX_PASSES];
    logic [SZ_W-1:0]        w_lvl_w   [MAX_PASSES];
    logic [SZ_W-1:0]        w_lvl_h   [MAX_PASSES];
    rbdc_pkg::t_cell_word   w_final;
    rbdc_pkg::t_fifo_status w_fifo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= rbdc_pkg::SIZE_RESET;
            r_src_h <= rbdc_pkg::SIZE_RESET;
            r_pass  <= rbdc_pkg::PASS_RESET;
        end else if (i_cfg_we) begin
            unique case (rbdc_pkg::t_cfg_index'(i_cfg_index))
                rbdc_pkg::CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                rbdc_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                rbdc_pkg::CFG_PASS_COUNT:    r_pass  <= i_cfg_data[rbdc_pkg::PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_src_w == '0) begin
            w_sw = SZ_W'(1);
        end else if (32'(r_src_w) > MAX_WIDTH) begin
            w_sw = SZ_W'(MAX_WIDTH);
        end else begin
            w_sw = SZ_W'(r_src_w);
        end
        priority if (r_src_h == '0) begin
            w_sh = SZ_W'(1);
        end else if (32'(r_src_h) > MAX_WIDTH) begin
            w_sh = SZ_W'(MAX_WIDTH);
        end else begin
            w_sh = SZ_W'(r_src_h);
        end
        priority if (r_pass == '0) begin
            w_np = NP_W'(1);
        end else if (32'(r_pass) > MAX_PASSES) begin
            w_np = NP_W'(MAX_PASSES);
        end else begin
            w_np = NP_W'(r_pass);
        end
    end

    assign w_en       = !w_fifo.full;
    assign i_in.ready = w_en;

    for (genvar p = 0; p < MAX_PASSES; p++) begin : g_cell
        assign w_lvl_w[p] = w_sw >> p;
        assign w_lvl_h[p] = w_sh >> p;
        if (p == 0) begin : g_head
            assign w_cell_in[p].valid = i_in.valid;
            assign w_cell_in[p].last  = 1'b0;
            assign w_cell_in[p].pixel = i_in.in_pixel;
        end else begin : g_tail
            assign w_cell_in[p].valid = w_link[p-1].valid && (NP_W'(p) < w_np);
            assign w_cell_in[p].last  = w_link[p-1].last;
            assign w_cell_in[p].pixel = w_link[p-1].pixel;
        end
        rbdc_cell #(
            .MAX_WIDTH (MAX_WIDTH),
            .STAGE     (p)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_width  (w_lvl_w[p]),
            .i_height (w_lvl_h[p]),
            .i_word   (w_cell_in[p]),
            .o_word   (w_link[p])
        );
    end

    always_comb begin
        w_final = w_link[0];
        for (int p = 0; p < MAX_PASSES; p++) begin
            if (NP_W'(p + 1) == w_np) begin
                w_final = w_link[p];
            end
        end
    end

    assign w_push = w_en && w_final.valid;

    rbdc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pixel  (w_final.pixel),
        .i_last   (w_final.last),
        .i_ready  (o_out.ready),
        .o_valid  (o_out.valid),
        .o_pixel  (o_out.out_pixel),
        .o_last   (o_out.out_last),
        .o_status (w_fifo)
    );

    assign o_out.final_width  = rbdc_pkg::FINAL_W'(32'(w_sw) >> w_np);
    assign o_out.final_height = rbdc_pkg::FINAL_W'(32'(w_sh) >> w_np);

    `RBDC_ASSERT(a_no_push_when_full, !(w_push && w_fifo.full), "push into full queue")
    `RBDC_ASSERT(a_valid_matches_fill, o_out.valid == !w_fifo.empty, "valid disagrees with fill")
    `RBDC_ASSERT(a_pass_in_range, (w_np != '0) && (32'(w_np) <= MAX_PASSES), "pass count out of range")
    `RBDC_ASSERT_NEXT(a_pop_drains, o_out.valid && o_out.ready && !w_push, w_fifo.count == $past(w_fifo.count) - 2'd1, "pop did not drain queue")

endmodule
`default_nettype wire

/* test/tb_rbdc_pixel_check.sv */
// Pixel checker for the downsample chain: predicts final-level words and compares them.
module tb_rbdc_pixel_check (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    rbdc_in_if                               i_in_mon,
    rbdc_out_if                              i_out_mon,
    input  wire                              i_cfg_we,
    input  wire [rbdc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [rbdc_pkg::CFG_W-1:0]        i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int HALF_WIDTH  = rbdc_pkg::MAX_WIDTH / 2;
    localparam int LEVELS      = rbdc_pkg::MAX_PASSES;
    localparam logic [31:0] LANE_MASK =
        {4{8'(rbdc_pkg::CHANNEL_MASK / rbdc_pkg::BOX_TAPS)}};

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic [11:0] width;
        logic [11:0] height;
    } mip_word_t;

    logic [rbdc_pkg::CFG_W-1:0]  width_reg;
    logic [rbdc_pkg::CFG_W-1:0]  height_reg;
    logic [rbdc_pkg::PASS_W-1:0] passes_reg;

    logic [31:0] first_pairs [HALF_WIDTH];
    logic [31:0] deep_pairs  [HALF_WIDTH];
    logic [31:0] even_quarter [LEVELS];
    int          col_pos [LEVELS];
    int          row_pos [LEVELS];

    mip_word_t   mip_q [$];
    int          mismatches = 0;

    function automatic int clamp_dim(input logic [rbdc_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > rbdc_pkg::MAX_WIDTH) return rbdc_pkg::MAX_WIDTH;
        return int'(v);
    endfunction

    // One halving level; true when it hands a word to the next level.
    function automatic bit halve_level(input int p, input int w, input int h,
                                       inout logic [31:0] px, inout bit last);
        int c, r, hw, hh, idx, addr;
        logic [31:0] s;
        c  = col_pos[p];
        r  = row_pos[p];
        hw = w >> 1;
        hh = h >> 1;
        if (c + 1 >= w) begin
            col_pos[p] = 0;
            row_pos[p] = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos[p] = c + 1;
        end
        if (c >= 2 * hw || r >= 2 * hh) return 1'b0;
        idx  = c >> 1;
        addr = (p == 0) ? idx : HALF_WIDTH - (rbdc_pkg::MAX_WIDTH >> p) + idx;
        if (addr >= HALF_WIDTH) return 1'b0;
        if ((c & 1) == 0) begin
            even_quarter[p] = (px >> 2) & LANE_MASK;
            return 1'b0;
        end
        s = even_quarter[p] + ((px >> 2) & LANE_MASK);
        if ((r & 1) == 0) begin
            if (p == 0) first_pairs[addr] = s;
            else deep_pairs[addr] = s;
            return 1'b0;
        end
        px   = s + ((p == 0) ? first_pairs[addr] : deep_pairs[addr]);
        last = (idx + 1 == hw) && ((r >> 1) + 1 == hh);
        return 1'b1;
    endfunction

    task automatic predict_word(input logic [31:0] px_in);
        int        sw, sh, np;
        logic [31:0] px;
        bit        last;
        mip_word_t e;
        sw   = clamp_dim(width_reg);
        sh   = clamp_dim(height_reg);
        np   = (passes_reg == 0) ? 1 :
               (passes_reg > LEVELS) ? LEVELS : int'(passes_reg);
        px   = px_in;
        last = 1'b0;
        for (int p = 0; p < np; p++) begin
            if (!halve_level(p, sw >> p, sh >> p, px, last)) return;
        end
        e.pixel  = px;
        e.last   = last;
        e.width  = 12'(sw >> np);
        e.height = 12'(sh >> np);
        mip_q.push_back(e);
    endtask

    always @(posedge i_clk) begin : watch
        mip_word_t got, want;
        if (!i_rst_n) begin
            width_reg  = rbdc_pkg::SIZE_RESET;
            height_reg = rbdc_pkg::SIZE_RESET;
            passes_reg = rbdc_pkg::PASS_RESET;
            for (int p = 0; p < LEVELS; p++) begin
                even_quarter[p] = '0;
                col_pos[p]      = 0;
                row_pos[p]      = 0;
            end
            mip_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rbdc_pkg::CFG_SOURCE_WIDTH:  width_reg  = i_cfg_data;
                    rbdc_pkg::CFG_SOURCE_HEIGHT: height_reg = i_cfg_data;
                    rbdc_pkg::CFG_PASS_COUNT:    passes_reg = i_cfg_data[rbdc_pkg::PASS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) predict_word(i_in_mon.in_pixel);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.pixel  = i_out_mon.out_pixel;
                got.last   = i_out_mon.out_last;
                got.width  = i_out_mon.final_width;
                got.height = i_out_mon.final_height;
                if (mip_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel_check: unexpected word pixel %h last %b size %0dx%0d",
                                 got.pixel, got.last, got.width, got.height);
                end else begin
                    want = mip_q.pop_front();
                    if (got.pixel !== want.pixel || got.last !== want.last ||
                        got.width !== want.width || got.height !== want.height) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel_check: exp pixel %h last %b size %0dx%0d,",
                                      " got pixel %h last %b size %0dx%0d"},
                                     want.pixel, want.last, want.width, want.height,
                                     got.pixel, got.last, got.width, got.height);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= mip_q.size();
    end

endmodule

/* test/tb_rgba_box_downsample_chain_core.sv */
// Testbench top: streams frames through the downsample chain and prints the verdict.
module tb_rgba_box_downsample_chain_core;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    localparam int SETTLE_CYCLES = rbdc_pkg::MAX_PASSES + 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_WORDS   = 100;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [rbdc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rbdc_pkg::CFG_W-1:0]       cfg_data;
    idle_mode_t                      phase_mode = IDLE_NONE;
    logic                            hold_req = 1'b0;
    int                              fail_count;
    int                              pending;
    int                              words_sent = 0;
    int                              idle_cycles = 0;

    rbdc_in_if  in_bus ();
    rbdc_out_if out_bus ();

    rgba_box_downsample_chain_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tb_rbdc_pixel_check pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic bit roll_idle(input bit receiver_side);
        case (phase_mode)
            IDLE_SENDER:   return !receiver_side && $urandom_range(0, 99) < 81;
            IDLE_RECEIVER: return receiver_side && $urandom_range(0, 99) < 81;
            IDLE_BOTH:     return $urandom_range(0, 99) < 8;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic int frame_dim(input logic [rbdc_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > rbdc_pkg::MAX_WIDTH) return rbdc_pkg::MAX_WIDTH;
        return int'(v);
    endfunction

    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_bus.ready <= i_rst_n && !roll_idle(1'b1);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("rgba_box_downsample_chain_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_words(input int count, input fill_t fill);
        logic [31:0] px;
        for (int k = 0; k < count; k++) begin
            case (fill)
                FILL_ONES:  px = '1;
                FILL_ZEROS: px = '0;
                default: begin
                    px = $urandom;
                    for (int b = 0; b < 4; b++) begin
                        if ($urandom_range(0, 7) == 0)
                            px[8*b +: 8] = {8{1'($urandom_range(0, 1))}};
                    end
                end
            endcase
            while (roll_idle(1'b0)) begin
                in_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_bus.valid    <= 1'b1;
            in_bus.in_pixel <= px;
            @(posedge i_clk);
            while (!in_bus.ready) @(posedge i_clk);
            words_sent++;
        end
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic format_frame(input logic [rbdc_pkg::CFG_W-1:0] w_reg,
                                input logic [rbdc_pkg::CFG_W-1:0] h_reg,
                                input logic [rbdc_pkg::PASS_W-1:0] p_reg);
        cfg_we    <= 1'b1;
        cfg_index <= rbdc_pkg::CFG_SOURCE_WIDTH;
        cfg_data  <= w_reg;
        @(posedge i_clk);
        cfg_index <= rbdc_pkg::CFG_SOURCE_HEIGHT;
        cfg_data  <= h_reg;
        @(posedge i_clk);
        cfg_index <= rbdc_pkg::CFG_PASS_COUNT;
        cfg_data  <= rbdc_pkg::CFG_W'(p_reg);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_frame(input logic [rbdc_pkg::CFG_W-1:0] w_reg,
                             input logic [rbdc_pkg::CFG_W-1:0] h_reg,
                             input logic [rbdc_pkg::PASS_W-1:0] p_reg,
                             input fill_t fill);
        wait_idle();
        format_frame(w_reg, h_reg, p_reg);
        send_words(frame_dim(w_reg) * frame_dim(h_reg), fill);
    endtask

    task automatic random_frame();
        int p, roll, w, h;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            run_frame(rbdc_pkg::CFG_W'($urandom_range(0, 3)),
                      rbdc_pkg::CFG_W'($urandom_range(0, 3)),
                      rbdc_pkg::PASS_W'($urandom_range(0, 15)),
                      FILL_RANDOM);
        end else begin
            p = (roll < 55) ? 1 : (roll < 88) ? 2 : 3;
            w = (1 << p) * $urandom_range(1, (p == 3) ? 2 : 3) + $urandom_range(0, 1);
            h = (1 << p) * $urandom_range(1, (p == 1) ? 3 : 1) + $urandom_range(0, 1);
            run_frame(rbdc_pkg::CFG_W'(w), rbdc_pkg::CFG_W'(h), rbdc_pkg::PASS_W'(p),
                      ($urandom_range(0, 15) == 0) ? FILL_ONES : FILL_RANDOM);
        end
    endtask

    initial begin : stimulus
        int start;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= rbdc_pkg::CFG_SOURCE_WIDTH;
        cfg_data        <= '0;
        in_bus.valid    <= 1'b0;
        in_bus.in_pixel <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_frame(2, 2, 1, FILL_ONES);
        run_frame(2, 2, 1, FILL_ZEROS);
        run_frame(3, 3, 1, FILL_RANDOM);
        run_frame(0, 2, 1, FILL_RANDOM);
        run_frame(3, 1, 1, FILL_RANDOM);
        run_frame(2, 2, 0, FILL_RANDOM);

        // shrink the height at a row-pair boundary
        wait_idle();
        format_frame(4, 6, 1);
        send_words(8, FILL_RANDOM);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= rbdc_pkg::CFG_SOURCE_HEIGHT;
        cfg_data  <= 4;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        send_words(8, FILL_RANDOM);

        hold_req <= 1'b1;
        run_frame(8, 4, 1, FILL_RANDOM);

        run_frame(4, 4, 15, FILL_ONES);
        run_frame(8, 8, 3, FILL_RANDOM);

        for (int m = 0; m < 4; m++) begin
            wait_idle();
            phase_mode <= idle_mode_t'(m);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) random_frame();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("rgba_box_downsample_chain_core: match");
        end else begin
            $display("rgba_box_downsample_chain_core: mismatch");
        end
        $finish;
    end

endmodule
